/* hdl/hex_record_stream_parser_assert.svh */
// Assertion macros for the hex record parser
`ifndef HEX_RECORD_STREAM_PARSER_ASSERT_SVH
`define HEX_RECORD_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define HRSP_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hrsp assertion failed");
`define HRSP_ASSERT_NEVER(name, expr) `HRSP_ASSERT(name, !(expr))
`else
`define HRSP_ASSERT(name, prop)
`define HRSP_ASSERT_NEVER(name, expr)
`endif

`endif

/* hdl/hrsp_pkg.sv */
`default_nettype none
package hrsp_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] TYPE_MAX   = 8'd5;
   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_RECORD = 1'b1;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_TYPE,
      PH_DATA,
      PH_CSUM
   } phase_type;

   typedef struct packed {
      logic        in_record;
      phase_type   field_phase;
      logic        low_nibble_next;
      logic [3:0]  high_nibble;
      logic [7:0]  count_held;
      logic [7:0]  bytes_left;
      logic [15:0] address_held;
      logic [7:0]  type_held;
      logic [7:0]  running_sum;
      logic [7:0]  data_offset;
   } parse_state_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [15:0] address;
      logic [7:0]  type_code;
      logic        type_known;
      logic [7:0]  payload_len;
      logic [7:0]  calc_checksum;
      logic        checksum_ok;
      logic        format_error;
   } result_type;

endpackage
`default_nettype wire

/* hdl/hrsp_step.sv */
`default_nettype none
module hrsp_step (
   input  wire logic [7:0]               char_in,
   input  wire hrsp_pkg::parse_state_type st,
   output hrsp_pkg::parse_state_type     st_next,
   output logic                          emit,
   output hrsp_pkg::result_type          res
);

   logic        is_hex;
   logic [3:0]  nib;
   logic [7:0]  b;
   logic [7:0]  calc;
   logic        known;
   hrsp_pkg::parse_state_type start_st;

   always_comb begin
      is_hex = 1'b1;
      nib    = 4'd0;
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         nib = 4'(char_in - 8'h30);
      end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
         nib = 4'(char_in - 8'h37);
      end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
         nib = 4'(char_in - 8'h57);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign b     = {st.high_nibble, nib};
   assign calc  = 8'(~st.running_sum + 8'd1);
   assign known = (st.type_held <= hrsp_pkg::TYPE_MAX);

   always_comb begin
      start_st           = '0;
      start_st.in_record = 1'b1;
   end

   always_comb begin
      st_next = st;
      emit    = 1'b0;
      res                 = '0;
      res.kind            = hrsp_pkg::KIND_RECORD;
      res.address         = st.address_held;
      res.type_code       = st.type_held;
      res.type_known      = known;
      res.payload_len     = st.count_held;
      res.calc_checksum   = calc;

      if (!st.in_record) begin
         if (char_in == hrsp_pkg::CHAR_COLON) begin
            st_next = start_st;
         end
      end else if (!is_hex) begin
         emit             = 1'b1;
         res.format_error = 1'b1;
         st_next.in_record = 1'b0;
         if (char_in == hrsp_pkg::CHAR_COLON) begin
            st_next = start_st;
         end
      end else if (!st.low_nibble_next) begin
         st_next.high_nibble     = nib;
         st_next.low_nibble_next = 1'b1;
      end else begin
         st_next.low_nibble_next = 1'b0;
         st_next.running_sum     = 8'(st.running_sum + b);
         unique case (st.field_phase)
            hrsp_pkg::PH_COUNT: begin
               st_next.count_held  = b;
               st_next.bytes_left  = b;
               st_next.field_phase = hrsp_pkg::PH_ADDR_HI;
            end
            hrsp_pkg::PH_ADDR_HI: begin
               st_next.address_held = {b, 8'd0};
               st_next.field_phase  = hrsp_pkg::PH_ADDR_LO;
            end
            hrsp_pkg::PH_ADDR_LO: begin
               st_next.address_held = {st.address_held[15:8], b};
               st_next.field_phase  = hrsp_pkg::PH_TYPE;
            end
            hrsp_pkg::PH_TYPE: begin
               st_next.type_held   = b;
               st_next.field_phase = (st.bytes_left != 8'd0) ? hrsp_pkg::PH_DATA
                                                             : hrsp_pkg::PH_CSUM;
            end
            hrsp_pkg::PH_DATA: begin
               emit                = 1'b1;
               res.kind            = hrsp_pkg::KIND_DATA;
               res.data_byte       = b;
               res.address         = 16'(st.address_held + {8'd0, st.data_offset});
               res.calc_checksum   = 8'd0;
               st_next.data_offset = 8'(st.data_offset + 8'd1);
               st_next.bytes_left  = 8'(st.bytes_left - 8'd1);
               if (st.bytes_left == 8'd1) begin
                  st_next.field_phase = hrsp_pkg::PH_CSUM;
               end
            end
            default: begin
               // checksum pair; unused phase codes behave the same
               emit              = 1'b1;
               res.checksum_ok   = (calc == b);
               st_next.in_record = 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* hdl/hex_record_stream_parser.sv */
// Path from request accept to rsp_valid: input register, then result register.
// Throughput: one character per cycle; input stalls only while a result waits on rsp_ready.
// Characters that produce no result never stall.
// Reset: synchronous, active high; clears parser state and both valid flags.
`default_nettype none
`include "hex_record_stream_parser_assert.svh"
module hex_record_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_address,
   output logic [7:0]       rsp_type_code,
   output logic             rsp_type_known,
   output logic [7:0]       rsp_payload_len,
   output logic [7:0]       rsp_calc_checksum,
   output logic             rsp_checksum_ok,
   output logic             rsp_format_error
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                char_ff;
   hrsp_pkg::parse_state_type state_ff, state_in;
   logic                      out_valid_ff, out_valid_in;
   hrsp_pkg::result_type      out_ff;
   hrsp_pkg::result_type      res;
   logic                      emit;
   logic                      advance;

   hrsp_step u_step (
      .char_in (char_ff),
      .st      (state_ff),
      .st_next (state_in),
      .emit    (emit),
      .res     (res)
   );

   assign advance   = in_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_in;
      end
      if (advance && emit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_address       = out_ff.address;
   assign rsp_type_code     = out_ff.type_code;
   assign rsp_type_known    = out_ff.type_known;
   assign rsp_payload_len   = out_ff.payload_len;
   assign rsp_calc_checksum = out_ff.calc_checksum;
   assign rsp_checksum_ok   = out_ff.checksum_ok;
   assign rsp_format_error  = out_ff.format_error;

   `HRSP_ASSERT(a_emit_lands, advance && emit |=> rsp_valid)
   `HRSP_ASSERT(a_stall_cause, in_valid_ff && !req_ready |-> out_valid_ff && emit)
   `HRSP_ASSERT(a_idle_stays,
      advance && !state_ff.in_record && char_ff != hrsp_pkg::CHAR_COLON |=>
      !state_ff.in_record)
   `HRSP_ASSERT_NEVER(a_data_flags,
      rsp_valid && rsp_kind == hrsp_pkg::KIND_DATA && (rsp_checksum_ok || rsp_format_error))
   `HRSP_ASSERT(a_data_addr,
      advance && emit && res.kind == hrsp_pkg::KIND_DATA |=>
      rsp_address == 16'($past(state_ff.address_held) + {8'd0, $past(state_ff.data_offset)}))

endmodule
`default_nettype wire
